/* rtl/ssg_pkg.sv */
// ----------------------------------------------------------------------------
// ssg_pkg: shared types and constants for the swept sine tone generator
// Holds the configuration bundle passed from the register file to the core
// and the register reset values.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam logic [31:0] START_FREQ_RESET   = 32'd39370534;
  localparam logic [31:0] RESTART_FREQ_RESET = 32'd7292497;
  localparam logic        SWEEP_EN_RESET     = 1'b1;
  localparam logic [15:0] AMPLITUDE_RESET    = 16'd16384;
  localparam logic [16:0] BLOCK_LEN_RESET    = 17'd1024;

  // freq_load is high in the cycle of a start word write; the core then takes
  // the written value from the bus at that same edge.
  typedef struct packed {
    logic [31:0] restart_freq_word;
    logic        sweep_enable;
    logic [15:0] amplitude;
    logic [16:0] block_len;
    logic        freq_load;
  } ssg_cfg_t;

endpackage

/* rtl/ssg_ram.sv */
// ----------------------------------------------------------------------------
// ssg_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ssg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ssg_sine_builder.sv */
// ----------------------------------------------------------------------------
// ssg_sine_builder: quarter-wave sine table fill engine
// After reset, evaluates a Taylor series for each quarter-wave entry, dividing
// each term by a reciprocal multiplication with a one-step correction, and
// writes the rounded Q15 magnitude into the table RAM. Raises done when the
// last entry is written.
// ----------------------------------------------------------------------------
module ssg_sine_builder #(
  parameter int TABLE_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  output logic                  we,
  output logic [TABLE_BITS-2:0] waddr,
  output logic [14:0]           wdata,
  output logic                  done
);

  localparam int QTR_BITS = TABLE_BITS - 2;
  localparam int K_W      = TABLE_BITS - 1;
  localparam int XP_W     = K_W + 31;
  localparam logic [K_W-1:0] QTR_IDX = K_W'(1 << QTR_BITS);
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  localparam logic [2:0] B_X    = 3'd0;
  localparam logic [2:0] B_X2   = 3'd1;
  localparam logic [2:0] B_MUL  = 3'd2;
  localparam logic [2:0] B_DIV  = 3'd3;
  localparam logic [2:0] B_FIX  = 3'd4;
  localparam logic [2:0] B_ACC  = 3'd5;
  localparam logic [2:0] B_OUT  = 3'd6;
  localparam logic [2:0] B_DONE = 3'd7;

  logic [2:0]         state;
  logic [K_W-1:0]     k;
  logic [30:0]        x;
  logic [31:0]        x2;
  logic [30:0]        term;
  logic signed [32:0] sum;
  logic [2:0]         n;
  logic [31:0]        dvd;
  logic [31:0]        q0;
  logic [31:0]        quo;

  logic [XP_W-1:0] xprod;
  logic [30:0]     x_val;
  logic [61:0]     x2prod;
  logic [62:0]     tprod;
  logic [7:0]      divisor;
  logic [31:0]     recip;
  logic [63:0]     qprod;
  logic [39:0]     qd;
  logic [31:0]     rem_chk;
  logic            rem_ge;
  logic [31:0]     sum_pos;
  logic [46:0]     vprod;
  logic [47:0]     vround;
  logic [17:0]     vq;
  logic [14:0]     v_val;

  // Divisor of term n, (2n)(2n+1), and floor(2^32 / divisor) for n = 1 to 5.
  always_comb begin
    case (n)
      3'd1: begin
        divisor = 8'd6;
        recip   = 32'd715827882;
      end
      3'd2: begin
        divisor = 8'd20;
        recip   = 32'd214748364;
      end
      3'd3: begin
        divisor = 8'd42;
        recip   = 32'd102261126;
      end
      3'd4: begin
        divisor = 8'd72;
        recip   = 32'd59652323;
      end
      3'd5: begin
        divisor = 8'd110;
        recip   = 32'd39045157;
      end
      default: begin
        divisor = 8'd156;
        recip   = 32'd27532995;
      end
    endcase
  end

  assign xprod  = XP_W'(k) * XP_W'(HALF_PI_Q30);
  assign x_val  = xprod[QTR_BITS +: 31];
  assign x2prod = x * x;
  assign tprod  = 63'(term) * 63'(x2);

  // For n = 1 to 5 the reciprocal estimate is the true quotient or one below
  // it, so the remainder is below twice the divisor and one compare fixes it.
  assign qprod   = 64'(dvd) * 64'(recip);
  assign qd      = 40'(q0) * 40'(divisor);
  assign rem_chk = dvd - qd[31:0];
  assign rem_ge  = rem_chk >= 32'(divisor);

  // Round the Q30 sum to Q15: sum * 32767 done as a shift and subtract.
  assign sum_pos = sum[32] ? 32'd0 : sum[31:0];
  assign vprod   = {sum_pos, 15'd0} - 47'(sum_pos);
  assign vround  = 48'(vprod) + 48'(1 << 29);
  assign vq      = vround[47:30];
  assign v_val   = (vq > 18'd32767) ? 15'd32767 : vq[14:0];

  assign we    = (state == B_OUT);
  assign waddr = k;
  assign wdata = v_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_X;
      k     <= '0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        B_X: begin
          x     <= x_val;
          term  <= x_val;
          sum   <= $signed({2'b00, x_val});
          state <= B_X2;
        end
        B_X2: begin
          x2    <= x2prod[61:30];
          n     <= 3'd1;
          state <= B_MUL;
        end
        B_MUL: begin
          dvd   <= tprod[61:30];
          state <= B_DIV;
        end
        B_DIV: begin
          q0    <= qprod[63:32];
          state <= B_FIX;
        end
        B_FIX: begin
          quo   <= q0 + 32'(rem_ge);
          state <= B_ACC;
        end
        B_ACC: begin
          term <= quo[30:0];
          if (n[0]) begin
            sum <= sum - $signed({2'b00, quo[30:0]});
          end else begin
            sum <= sum + $signed({2'b00, quo[30:0]});
          end
          if (n == 3'd6) begin
            state <= B_OUT;
          end else begin
            n     <= n + 3'd1;
            state <= B_MUL;
          end
        end
        B_OUT: begin
          if (k == QTR_IDX) begin
            done  <= 1'b1;
            state <= B_DONE;
          end else begin
            k     <= k + K_W'(1);
            state <= B_X;
          end
        end
        B_DONE: begin
          state <= B_DONE;
        end
        default: begin
          state <= B_X;
        end
      endcase
    end
  end

endmodule

/* rtl/ssg_regs.sv */
// ----------------------------------------------------------------------------
// ssg_regs: configuration register file
// APB-style slave holding start and restart frequency words, sweep enable,
// amplitude and block length. A write of the start word also flags a reload
// of the running frequency.
// ----------------------------------------------------------------------------
module ssg_regs (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output ssg_pkg::ssg_cfg_t cfg
);

  import ssg_pkg::*;

  localparam logic [2:0] REG_START_FREQ   = 3'd0;
  localparam logic [2:0] REG_RESTART_FREQ = 3'd1;
  localparam logic [2:0] REG_SWEEP_EN     = 3'd2;
  localparam logic [2:0] REG_AMPLITUDE    = 3'd3;
  localparam logic [2:0] REG_BLOCK_LEN    = 3'd4;

  logic [31:0] start_freq_word;
  logic [31:0] restart_freq_word;
  logic        sweep_enable;
  logic [15:0] amplitude;
  logic [16:0] block_len;
  logic        wr;
  logic [2:0]  index;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign index  = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      start_freq_word   <= START_FREQ_RESET;
      restart_freq_word <= RESTART_FREQ_RESET;
      sweep_enable      <= SWEEP_EN_RESET;
      amplitude         <= AMPLITUDE_RESET;
      block_len         <= BLOCK_LEN_RESET;
    end else begin
      if (wr) begin
        unique case (index)
          REG_START_FREQ:   start_freq_word   <= pwdata;
          REG_RESTART_FREQ: restart_freq_word <= pwdata;
          REG_SWEEP_EN:     sweep_enable      <= pwdata[0];
          REG_AMPLITUDE:    amplitude         <= pwdata[15:0];
          REG_BLOCK_LEN:    block_len         <= pwdata[16:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (index)
      REG_START_FREQ:   prdata = start_freq_word;
      REG_RESTART_FREQ: prdata = restart_freq_word;
      REG_SWEEP_EN:     prdata = 32'(sweep_enable);
      REG_AMPLITUDE:    prdata = 32'(amplitude);
      REG_BLOCK_LEN:    prdata = 32'(block_len);
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg.restart_freq_word = restart_freq_word;
  assign cfg.sweep_enable      = sweep_enable;
  assign cfg.amplitude         = amplitude;
  assign cfg.block_len         = block_len;
  assign cfg.freq_load         = wr && (index == REG_START_FREQ);

endmodule

/* rtl/swept_sine_tone_generator_top.sv */
// ----------------------------------------------------------------------------
// swept_sine_tone_generator_top: swept sine test-tone generator
// Direct digital synthesis from a quarter-wave sine table RAM, with a sweep
// check at buffer starts that doubles the frequency word, or wraps to restart.
// ----------------------------------------------------------------------------
// After reset the block builds its quarter-wave sine table in RAM; s_tready
// stays low until then, while register writes are taken as usual. Each item
// then passes through the sweep update, the 32x32 phase multiply, the table
// RAM read, the gain multiply and the rounding stage one after the other, and
// no new item is taken until it is through. A finished result sits in the
// output register, so a new item can be taken while it waits for m_tready.
// Writes to the start frequency word reload the running frequency at the same
// clock edge.
module swept_sine_tone_generator_top #(
  parameter int PHASE_BITS   = 32,
  parameter int TABLE_BITS   = 12,
  parameter int SWEEP_BLOCKS = 20
) (
  input  logic        clk,
  input  logic        rst,
  // Input item.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [0] block_start
  // Result item.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [15:0] sample, [47:16] freq_word
  output logic [0:0]  m_tuser,   // [0] swept
  // Configuration.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import ssg_pkg::*;

  localparam int QTR_BITS  = TABLE_BITS - 2;
  localparam int ADDR_W    = TABLE_BITS - 1;
  localparam int QTR_DEPTH = (1 << QTR_BITS) + 1;
  localparam int SB_W      = $clog2(SWEEP_BLOCKS + 1);
  localparam int LIMIT_W   = 17 + SB_W;
  localparam logic [ADDR_W-1:0] QTR_ADDR = ADDR_W'(1 << QTR_BITS);
  localparam logic [63:0] NYQUIST = 64'd1 << (PHASE_BITS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_SAT   = 3'd4;

  ssg_cfg_t cfg;

  logic                  fill_we;
  logic [ADDR_W-1:0]     fill_addr;
  logic [14:0]           fill_data;
  logic                  fill_done;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     raddr;
  logic [14:0]           rdata;

  logic [2:0]            state;
  logic [31:0]           sample_time;
  logic [31:0]           current_freq;
  logic [31:0]           since_check;
  logic                  first_done;
  logic [LIMIT_W-1:0]    limit;
  logic [31:0]           time_q;
  logic                  fired_q;
  logic [TABLE_BITS-1:0] idx;
  logic signed [32:0]    prod;

  logic                  in_acc;
  logic                  fired;
  logic [32:0]           dbl;
  logic                  wrap;
  logic [63:0]           phase_prod;
  logic [QTR_BITS-1:0]   r;
  logic [15:0]           rom_mag;
  logic signed [15:0]    rom_val;
  logic signed [32:0]    prod_val;
  logic signed [32:0]    rnd;
  logic signed [18:0]    scaled;
  logic [15:0]           sample_val;
  logic                  out_load;

  ssg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ssg_sine_builder #(
    .TABLE_BITS (TABLE_BITS)
  ) u_builder (
    .clk   (clk),
    .rst   (rst),
    .we    (fill_we),
    .waddr (fill_addr),
    .wdata (fill_data),
    .done  (fill_done)
  );

  assign ram_waddr = fill_addr;

  ssg_ram #(
    .WIDTH (15),
    .DEPTH (QTR_DEPTH)
  ) u_sine_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (ram_waddr),
    .wdata (fill_data),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign s_tready = fill_done && (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;

  // Sweep check and frequency doubling.
  assign limit = LIMIT_W'(cfg.block_len) * LIMIT_W'(SWEEP_BLOCKS);
  assign fired = s_tdata[0] && (!first_done || (since_check > 32'(limit)));
  assign dbl   = {current_freq, 1'b0};
  assign wrap  = dbl[32] || ({31'd0, dbl} >= NYQUIST);

  assign phase_prod = 64'(time_q) * 64'(current_freq);

  // Quarter-wave mirroring: odd quarters read backwards, the second half is
  // negated.
  assign r     = idx[QTR_BITS-1:0];
  assign raddr = idx[TABLE_BITS-2] ? (QTR_ADDR - ADDR_W'(r)) : ADDR_W'(r);

  assign rom_mag  = {1'b0, rdata};
  assign rom_val  = idx[TABLE_BITS-1] ? $signed(16'd0 - rom_mag) : $signed(rom_mag);
  assign prod_val = rom_val * $signed({1'b0, cfg.amplitude});

  assign rnd    = prod + 33'sd8192;
  assign scaled = rnd[32:14];

  always_comb begin
    if (scaled > 19'sd32767) begin
      sample_val = 16'sd32767;
    end else if (scaled < -19'sd32767) begin
      sample_val = -16'sd32767;
    end else begin
      sample_val = scaled[15:0];
    end
  end

  assign out_load = (state == S_SAT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_time  <= 32'd0;
      current_freq <= START_FREQ_RESET;
      since_check  <= 32'd0;
      first_done   <= 1'b0;
    end else begin
      if (cfg.freq_load) begin
        current_freq <= pwdata;
      end else if (in_acc && fired && cfg.sweep_enable) begin
        current_freq <= wrap ? cfg.restart_freq_word : dbl[31:0];
      end

      if (in_acc) begin
        sample_time <= sample_time + 32'd1;
        if (fired) begin
          since_check <= 32'd1;
          first_done  <= 1'b1;
        end else if (since_check != 32'hFFFF_FFFF) begin
          since_check <= since_check + 32'd1;
        end
      end

      unique case (state)
        S_IDLE:  if (in_acc) state <= S_MUL;
        S_MUL:   state <= S_RD;
        S_RD:    state <= S_SCALE;
        S_SCALE: state <= S_SAT;
        S_SAT:   if (out_load) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      time_q  <= sample_time;
      fired_q <= fired;
    end
    if (state == S_MUL) begin
      idx <= phase_prod[PHASE_BITS-1 -: TABLE_BITS];
    end
    if (state == S_SCALE) begin
      prod <= prod_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {current_freq, sample_val};
      m_tuser <= fired_q;
    end
  end

endmodule

/* verif/swept_sine_tone_generator_top_tb.sv */
// ----------------------------------------------------------------------------
// swept_sine_tone_generator_top_tb: self-checking bench for the tone generator
// Walks a short table of directed requests and register writes, then runs
// random phases of buffer-shaped requests under several settings and idling
// patterns. Each result item is compared with an in-bench model of the sweep
// logic, phase product, sine table and gain stage, unless its row fixes a tone.
// ----------------------------------------------------------------------------
module swept_sine_tone_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ssg_pkg::*;

  localparam int SWEEP_BLOCKS    = 20;
  localparam int STALL_LIMIT     = 700000;
  localparam int SETTLE_CYCLES   = 12;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_CYCLES     = 400;

  typedef enum logic {STEP_ITEM, STEP_WRITE} step_kind_e;

  typedef enum logic [2:0] {
    REG_START_FREQ   = 3'd0,
    REG_RESTART_FREQ = 3'd1,
    REG_SWEEP_EN     = 3'd2,
    REG_AMPLITUDE    = 3'd3,
    REG_BLOCK_LEN    = 3'd4,
    REG_UNUSED       = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [15:0] sample;
    logic [31:0]        freq;
    logic               swept;
  } tone_t;

  typedef struct packed {
    step_kind_e  kind;
    reg_idx_e    idx;
    logic [31:0] value;
    logic        block_start;
    logic        typed;
    tone_t       tone;
  } plan_row_t;

  localparam tone_t NO_TONE = '0;

  localparam plan_row_t DIRECTED_PLAN [0:31] = '{
    // The first buffer after reset always runs the sweep check.
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b1, '{16'sd0, 32'd78741068, 1'b1}},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    // Zero block length: every buffer start after a sample fires a check.
    '{STEP_WRITE, REG_BLOCK_LEN,    32'd0,         1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_AMPLITUDE,    32'd65535,     1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b0, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_AMPLITUDE,    32'd0,         1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b0, 1'b1, '{16'sd0, 32'd7292497, 1'b0}},
    // Sweep disabled: the check fires but the frequency stays.
    '{STEP_WRITE, REG_SWEEP_EN,     32'd0,         1'b0, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_AMPLITUDE,    32'hFFFF_FFFF, 1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_START_FREQ,   32'hFFFF_FFFF, 1'b0, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_SWEEP_EN,     32'hFFFF_FFFF, 1'b0, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_RESTART_FREQ, 32'd0,         1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b0, 1'b0, NO_TONE},
    // Doubling overflows 32 bits, so the restart word of zero is taken.
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b1, '{16'sd0, 32'd0, 1'b1}},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b1, '{16'sd0, 32'd0, 1'b1}},
    '{STEP_WRITE, REG_RESTART_FREQ, 32'hFFFF_FFFF, 1'b0, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_START_FREQ,   32'h4000_0000, 1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_UNUSED,       32'hFFFF_FFFF, 1'b0, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_BLOCK_LEN,    32'hFFFF_FFFF, 1'b0, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b1, 1'b0, NO_TONE},
    '{STEP_ITEM,  REG_UNUSED,       32'd0,         1'b0, 1'b0, NO_TONE},
    '{STEP_WRITE, REG_BLOCK_LEN,    32'd1,         1'b0, 1'b0, NO_TONE}
  };

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;   // [0] block_start
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;         // [15:0] sample, [47:16] freq_word
  logic [0:0]  m_tuser;         // [0] swept
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  swept_sine_tone_generator_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Register mirror and generator state.
  logic [31:0] cfg_start    = START_FREQ_RESET;
  logic [31:0] cfg_restart  = RESTART_FREQ_RESET;
  logic        cfg_sweep    = SWEEP_EN_RESET;
  logic [15:0] cfg_amp      = AMPLITUDE_RESET;
  logic [16:0] cfg_blen     = BLOCK_LEN_RESET;
  logic [31:0] sample_clock = '0;
  logic [31:0] run_freq     = START_FREQ_RESET;
  logic [31:0] since_sweep  = '0;
  logic        checked_once = 1'b0;

  logic signed [15:0] sine_rom [0:4095];
  int                 quarter_wave [0:1024];

  tone_t expected_tones [$];
  int    fail_count     = 0;
  int    src_idle_pct   = 0;
  int    sink_stall_pct = 0;
  logic  hold_request   = 1'b0;
  int    hold_left      = 0;
  int    quiet_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Quarter wave by a Taylor series in Q30, mirrored into the full table.
  function automatic void build_sine_rom();
    longint unsigned x, x2, term, v;
    longint          sum;
    int              q, r;
    for (int k = 0; k <= 1024; k++) begin
      x    = (64'(k) * 64'd1686629713) >> 10;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) v = 64'd32767;
      quarter_wave[k] = int'(v);
    end
    for (int k = 0; k < 4096; k++) begin
      q = (k >> 10) & 3;
      r = k & 1023;
      case (q)
        0: sine_rom[k] = 16'(quarter_wave[r]);
        1: sine_rom[k] = 16'(quarter_wave[1024 - r]);
        2: sine_rom[k] = 16'(-quarter_wave[r]);
        default: sine_rom[k] = 16'(-quarter_wave[1024 - r]);
      endcase
    end
  endfunction

  function automatic tone_t predict_tone(input logic block_start);
    tone_t       t;
    logic [63:0] doubled;
    logic [31:0] phase;
    longint      prod, scaled;
    t.swept = 1'b0;
    if (block_start && (!checked_once ||
        64'(since_sweep) > 64'(SWEEP_BLOCKS) * 64'(cfg_blen))) begin
      t.swept = 1'b1;
      if (cfg_sweep) begin
        doubled = 64'(run_freq) * 64'd2;
        if (doubled >= 64'h8000_0000) run_freq = cfg_restart;
        else run_freq = doubled[31:0];
      end
      since_sweep  = '0;
      checked_once = 1'b1;
    end
    phase  = sample_clock * run_freq;
    prod   = longint'(sine_rom[phase[31:20]]) * longint'(cfg_amp);
    scaled = (prod + 64'sd8192) >>> 14;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32767) scaled = -32767;
    t.sample = 16'(scaled);
    t.freq   = run_freq;
    sample_clock = sample_clock + 32'd1;
    if (since_sweep != 32'hFFFF_FFFF) since_sweep = since_sweep + 32'd1;
    return t;
  endfunction

  function automatic logic [31:0] pick_freq_word();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h4000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'd1;
      default: return $urandom();
    endcase
  endfunction

  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_START_FREQ: begin
        cfg_start = value;
        run_freq  = value;
      end
      REG_RESTART_FREQ: cfg_restart = value;
      REG_SWEEP_EN:     cfg_sweep   = value[0];
      REG_AMPLITUDE:    cfg_amp     = value[15:0];
      REG_BLOCK_LEN:    cfg_blen    = value[16:0];
      default: ;
    endcase
  endtask

  task automatic send_tone_request(input logic block_start, input logic typed,
                                   input tone_t typed_tone);
    tone_t want;
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, block_start};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    want = predict_tone(block_start);
    if (typed) want = typed_tone;
    expected_tones.push_back(want);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering, wait for every pending tone, then let the pipeline settle.
  task automatic drain_tones();
    s_tvalid <= 1'b0;
    while (expected_tones.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_tones
    tone_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.sample = m_tdata[15:0];
      got.freq   = m_tdata[47:16];
      got.swept  = m_tuser[0];
      if (expected_tones.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected item: sample %0d freq %h swept %b",
                   got.sample, got.freq, got.swept);
      end else begin
        want = expected_tones.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected sample %0d freq %h swept %b, got sample %0d freq %h swept %b",
                     want.sample, want.freq, want.swept, got.sample, got.freq, got.swept);
        end
      end
    end
  end

  // The table build after reset keeps the input stalled; the watchdog allows for it.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
    else quiet_cycles = quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    plan_row_t row;
    int        buf_left;
    logic      block_start;
    build_sine_rom();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_PLAN[i]) begin
      row = DIRECTED_PLAN[i];
      if (row.kind == STEP_WRITE) begin
        drain_tones();
        apb_write(row.idx, row.value);
      end else begin
        send_tone_request(row.block_start, row.typed, row.tone);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain_tones();
      if ($urandom_range(0, 9) < 6) apb_write(REG_START_FREQ, pick_freq_word());
      if ($urandom_range(0, 9) < 6) apb_write(REG_RESTART_FREQ, pick_freq_word());
      if ($urandom_range(0, 9) < 6) apb_write(REG_SWEEP_EN, $urandom());
      if ($urandom_range(0, 9) < 6) begin
        case ($urandom_range(0, 3))
          0: apb_write(REG_AMPLITUDE, 32'd0);
          1: apb_write(REG_AMPLITUDE, 32'd65535);
          2: apb_write(REG_AMPLITUDE, 32'd16384);
          default: apb_write(REG_AMPLITUDE, $urandom());
        endcase
      end
      // Short buffers keep the sweep checks frequent.
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 7))
          0: apb_write(REG_BLOCK_LEN, 32'd65536);
          1: apb_write(REG_BLOCK_LEN, $urandom());
          default: apb_write(REG_BLOCK_LEN, $urandom_range(0, 6));
        endcase
      end

      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 86; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 86; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      // The receiver holds off while requests keep coming, so the block backs up.
      if (ph == 4) hold_request = 1'b1;

      buf_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 6 && n == ITEMS_PER_PHASE / 2) drain_tones();
        if ($urandom_range(0, 9) == 0) begin
          block_start = $urandom_range(0, 1);
        end else if (buf_left == 0) begin
          block_start = 1'b1;
          if ($urandom_range(0, 4) != 0)
            buf_left = ((cfg_blen == 0) ? 1 : int'(cfg_blen)) - 1;
          else
            buf_left = $urandom_range(0, 5);
        end else begin
          block_start = 1'b0;
          buf_left--;
        end
        send_tone_request(block_start, 1'b0, NO_TONE);
      end
    end

    drain_tones();
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
